### rtl/core/unicode_escape_to_utf8_decoder_defines.svh
// assertion macros of the escape decoder modules, used by uesc_burst
`ifndef UNICODE_ESCAPE_TO_UTF8_DECODER_DEFINES_SVH
`define UNICODE_ESCAPE_TO_UTF8_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define UESC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UESC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UESC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define UESC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/uesc_pkg.sv
// types, constants and helpers of the escape decoder
package uesc_pkg;

    localparam int BURST_MAX = 5;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U      = 8'h75;

    localparam logic [15:0] CP_MAX_1B = 16'h007F;
    localparam logic [15:0] CP_MAX_2B = 16'h07FF;

    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] CONT_B  = 8'h80;

    // escape progress
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BSL  = 3'd1,
        PH_U    = 3'd2,
        PH_D1   = 3'd3,
        PH_D2   = 3'd4,
        PH_D3   = 3'd5
    } phase_t;

    // bytes caused by one request
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      text_last;
    } burst_t;

    // hex digit value, non-hex reads as zero
    function automatic logic [3:0] nib(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
        return v[3:0];
    endfunction

endpackage

### rtl/core/uesc_decode.sv
// escape state and per-request burst formation
module uesc_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic [7:0]      char_in,
    input  logic            last_char,
    output uesc_pkg::burst_t res
);

    uesc_pkg::phase_t phase_reg, phase_next;
    logic [11:0]      accum_reg, accum_next;
    logic [7:0]       held_reg [3];
    logic             held_we;
    logic [1:0]       held_idx;
    logic [15:0]      cp;
    logic [3:0]       dig;

    assign dig = uesc_pkg::nib(char_in);
    assign cp  = {accum_reg, dig};

    // burst and next state for the held request
    always_comb
    begin
        res            = '0;
        res.text_last  = last_char;
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        held_we        = 1'b0;
        held_idx       = 2'd0;
        case (phase_reg)
            uesc_pkg::PH_BSL:
            begin
                if (char_in == uesc_pkg::CHAR_U)
                begin
                    if (last_char)
                    begin
                        res.bytes[0] = uesc_pkg::CHAR_BSLASH;
                        res.bytes[1] = char_in;
                        res.cnt      = 3'd2;
                    end
                    else
                    begin
                        phase_next = uesc_pkg::PH_U;
                        accum_next = '0;
                    end
                end
                else
                begin
                    // lone backslash goes out raw, byte judged again from idle
                    res.bytes[0] = uesc_pkg::CHAR_BSLASH;
                    if (char_in == uesc_pkg::CHAR_BSLASH && !last_char)
                    begin
                        res.cnt    = 3'd1;
                        phase_next = uesc_pkg::PH_BSL;
                    end
                    else
                    begin
                        res.bytes[1] = char_in;
                        res.cnt      = 3'd2;
                        phase_next   = uesc_pkg::PH_IDLE;
                    end
                end
            end
            uesc_pkg::PH_U, uesc_pkg::PH_D1, uesc_pkg::PH_D2:
            begin
                if (last_char)
                begin
                    // partial escape flushed raw
                    res.bytes[0] = uesc_pkg::CHAR_BSLASH;
                    res.bytes[1] = uesc_pkg::CHAR_U;
                    res.bytes[2] = (phase_reg == uesc_pkg::PH_U)  ? char_in : held_reg[0];
                    res.bytes[3] = (phase_reg == uesc_pkg::PH_D1) ? char_in : held_reg[1];
                    res.bytes[4] = char_in;
                    case (phase_reg)
                        uesc_pkg::PH_U:  res.cnt = 3'd3;
                        uesc_pkg::PH_D1: res.cnt = 3'd4;
                        default:         res.cnt = 3'd5;
                    endcase
                end
                else
                begin
                    held_we    = 1'b1;
                    accum_next = {accum_reg[7:0], dig};
                    case (phase_reg)
                        uesc_pkg::PH_U:
                        begin
                            held_idx   = 2'd0;
                            phase_next = uesc_pkg::PH_D1;
                        end
                        uesc_pkg::PH_D1:
                        begin
                            held_idx   = 2'd1;
                            phase_next = uesc_pkg::PH_D2;
                        end
                        default:
                        begin
                            held_idx   = 2'd2;
                            phase_next = uesc_pkg::PH_D3;
                        end
                    endcase
                end
            end
            uesc_pkg::PH_D3:
            begin
                // utf-8 encode of the completed code point
                if (cp <= uesc_pkg::CP_MAX_1B)
                begin
                    res.bytes[0] = cp[7:0];
                    res.cnt      = 3'd1;
                end
                else if (cp <= uesc_pkg::CP_MAX_2B)
                begin
                    res.bytes[0] = uesc_pkg::LEAD_2B | {3'b000, cp[10:6]};
                    res.bytes[1] = uesc_pkg::CONT_B | {2'b00, cp[5:0]};
                    res.cnt      = 3'd2;
                end
                else
                begin
                    res.bytes[0] = uesc_pkg::LEAD_3B | {4'b0000, cp[15:12]};
                    res.bytes[1] = uesc_pkg::CONT_B | {2'b00, cp[11:6]};
                    res.bytes[2] = uesc_pkg::CONT_B | {2'b00, cp[5:0]};
                    res.cnt      = 3'd3;
                end
                phase_next = uesc_pkg::PH_IDLE;
                accum_next = '0;
            end
            default:
            begin
                if (char_in == uesc_pkg::CHAR_BSLASH && !last_char)
                begin
                    phase_next = uesc_pkg::PH_BSL;
                end
                else
                begin
                    res.bytes[0] = char_in;
                    res.cnt      = 3'd1;
                    phase_next   = uesc_pkg::PH_IDLE;
                end
            end
        endcase
        // end of text returns to idle
        if (last_char)
        begin
            phase_next = uesc_pkg::PH_IDLE;
            accum_next = '0;
        end
    end

    // escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uesc_pkg::PH_IDLE;
            accum_reg <= '0;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
        end
    end

    // raw digit characters of a pending escape
    always_ff @(posedge clk)
    begin
        if (adv && held_we)
        begin
            held_reg[held_idx] <= char_in;
        end
    end

endmodule

### rtl/core/uesc_burst.sv
// result register that drains one burst a byte per cycle while the output is not stalled
`include "unicode_escape_to_utf8_decoder_defines.svh"

module uesc_burst (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  uesc_pkg::burst_t res,
    output logic             free,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             text_end
);

    logic                           valid_reg;
    logic [uesc_pkg::BURST_MAX-1:0][7:0] bytes_reg;
    logic [2:0]                     cnt_reg;
    logic [2:0]                     idx_reg;
    logic                           tlast_reg;
    logic                           take;

    // output view of the current byte
    assign out_valid = valid_reg;
    assign out_byte  = bytes_reg[idx_reg];
    assign run_last  = (idx_reg == cnt_reg - 3'd1);
    assign text_end  = run_last && tlast_reg;
    assign take      = valid_reg && !out_stall;
    assign free      = !valid_reg || (take && run_last);

    // burst control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            if (run_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    // burst payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= res.bytes;
            cnt_reg   <= res.cnt;
            tlast_reg <= res.text_last;
        end
    end

    `UESC_ASSERT_IMP(a_load_when_free, clk, rst_n, load, free, "burst overwritten while pending")
    `UESC_ASSERT_IMP(a_idx_in_range, clk, rst_n, valid_reg, idx_reg < cnt_reg, "burst index beyond count")
    `UESC_ASSERT_IMP(a_load_nonempty, clk, rst_n, load, res.cnt != 3'd0, "empty burst loaded")
    `UESC_ASSERT_NXT(a_hold_on_stall, clk, rst_n, valid_reg && out_stall && !load, valid_reg && $stable(idx_reg), "stalled burst advanced")

endmodule

### rtl/core/unicode_escape_to_utf8_decoder.sv
// top level of the backslash-u escape to utf-8 decoder
// Takes one text byte per request and returns its UTF-8 output bytes one per cycle
// unless out_stall holds them. A request is taken every cycle as long as each yields
// at most one byte and out_stall is low; a request that yields several (a multi-byte
// code point or a flushed partial escape, up to five) holds the single output byte
// port until its last byte is taken, stalling later requests that yield bytes.
// A request passes an input register, then the decode into the burst register.
// Requests that yield nothing (held escape characters) pass without using the output.
module unicode_escape_to_utf8_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_end
);

    logic             inv_reg;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic             adv;
    logic             burst_free;
    uesc_pkg::burst_t res;

    // held request moves on when the burst register can take it or it yields nothing
    assign adv      = inv_reg && (burst_free || res.cnt == 3'd0);
    assign in_stall = inv_reg && !adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_reg <= 1'b0;
        else if (in_valid && !in_stall)
            inv_reg <= 1'b1;
        else if (adv)
            inv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= char_in;
            last_reg <= last_char;
        end
    end

    uesc_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .char_in   (char_reg),
        .last_char (last_reg),
        .res       (res)
    );

    uesc_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv && res.cnt != 3'd0),
        .res       (res),
        .free      (burst_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end)
    );

endmodule

### dv/tb_unicode_escape_to_utf8_decoder.sv
// testbench for the backslash-u escape to utf-8 decoder, checked by its own predictor
module tb_unicode_escape_to_utf8_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    // one text byte waiting to be sent
    typedef struct {
        logic [7:0] ch;
        logic       fin;
        int         gap;
        bit         drain;
    } text_req_t;

    // one decoded output byte
    typedef struct packed {
        logic [7:0] b;
        logic       run_end;
        logic       txt_end;
    } utf8_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] char_in = 8'h00;
    logic       last_char = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b1;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    text_req_t  text_q[$];
    utf8_byte_t utf8_expected[$];

    // predictor state
    uesc_pkg::phase_t esc_phase = uesc_pkg::PH_IDLE;
    logic [7:0] digit_hold [3];
    logic [11:0] cp_acc = '0;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int wait_cnt = 0;
    int stall_left = 0;
    int stall_draw = 0;
    int mismatches = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_texts = 0;
    int n_escapes = 0;

    unicode_escape_to_utf8_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end)
    );

    always #1ns clk = ~clk;

    // hex digit value, anything else reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c inside {[8'h30:8'h39]})
            v = c - 8'h30;
        else if (c inside {[8'h41:8'h46]})
            v = c - 8'h41 + 8'd10;
        else if (c inside {[8'h61:8'h66]})
            v = c - 8'h61 + 8'd10;
        return v[3:0];
    endfunction

    // work out the utf-8 bytes caused by one accepted request
    function automatic void predict_utf8(input logic [7:0] c, input logic fin);
        logic [7:0] outb[$];
        logic [15:0] cp;
        int idx;
        bit rejudge;
        utf8_byte_t e;
        rejudge = 1'b0;
        case (esc_phase)
            uesc_pkg::PH_BSL:
            begin
                if (c == uesc_pkg::CHAR_U)
                begin
                    if (fin)
                    begin
                        outb = {outb, uesc_pkg::CHAR_BSLASH};
                        outb = {outb, c};
                    end
                    else
                    begin
                        esc_phase = uesc_pkg::PH_U;
                        cp_acc = '0;
                    end
                end
                else
                begin
                    outb = {outb, uesc_pkg::CHAR_BSLASH};
                    rejudge = 1'b1;
                end
            end
            uesc_pkg::PH_U, uesc_pkg::PH_D1, uesc_pkg::PH_D2:
            begin
                idx = int'(esc_phase) - int'(uesc_pkg::PH_U);
                if (fin)
                begin
                    // partial escape flushed raw
                    outb = {outb, uesc_pkg::CHAR_BSLASH};
                    outb = {outb, uesc_pkg::CHAR_U};
                    for (int k = 0; k < idx; k++)
                        outb = {outb, digit_hold[k]};
                    outb = {outb, c};
                end
                else
                begin
                    digit_hold[idx] = c;
                    cp_acc = {cp_acc[7:0], hex_value(c)};
                    esc_phase = uesc_pkg::phase_t'(esc_phase + 3'd1);
                end
            end
            uesc_pkg::PH_D3:
            begin
                cp = {cp_acc, hex_value(c)};
                if (cp <= uesc_pkg::CP_MAX_1B)
                    outb = {outb, cp[7:0]};
                else if (cp <= uesc_pkg::CP_MAX_2B)
                begin
                    outb = {outb, uesc_pkg::LEAD_2B | {3'b000, cp[10:6]}};
                    outb = {outb, uesc_pkg::CONT_B | {2'b00, cp[5:0]}};
                end
                else
                begin
                    outb = {outb, uesc_pkg::LEAD_3B | {4'h0, cp[15:12]}};
                    outb = {outb, uesc_pkg::CONT_B | {2'b00, cp[11:6]}};
                    outb = {outb, uesc_pkg::CONT_B | {2'b00, cp[5:0]}};
                end
                esc_phase = uesc_pkg::PH_IDLE;
                cp_acc = '0;
            end
            default:
                rejudge = 1'b1;
        endcase
        // byte judged from idle, possibly after a backslash sent out raw
        if (rejudge)
        begin
            if (c == uesc_pkg::CHAR_BSLASH && !fin)
                esc_phase = uesc_pkg::PH_BSL;
            else
            begin
                esc_phase = uesc_pkg::PH_IDLE;
                outb = {outb, c};
            end
        end
        if (fin)
        begin
            esc_phase = uesc_pkg::PH_IDLE;
            cp_acc = '0;
        end
        foreach (outb[i])
        begin
            e.b = outb[i];
            e.run_end = (i == outb.size() - 1);
            e.txt_end = fin && (i == outb.size() - 1);
            utf8_expected = {utf8_expected, e};
        end
    endfunction

    task automatic push_char(input logic [7:0] c);
        text_req_t r;
        r.ch = c;
        r.fin = 1'b0;
        r.gap = tx_calm ? 0 : int'($urandom_range(0, 6));
        r.drain = 1'b0;
        text_q = {text_q, r};
    endtask

    // queue the first keep bytes of an escape for cp, digits in random case, some random if noisy
    task automatic add_escape(input logic [15:0] cp, input int keep, input bit noisy);
        logic [7:0] seq [6];
        logic [3:0] nb;
        seq[0] = uesc_pkg::CHAR_BSLASH;
        seq[1] = uesc_pkg::CHAR_U;
        for (int k = 0; k < 4; k++)
        begin
            nb = cp[15 - 4 * k -: 4];
            if (nb < 4'd10)
                seq[k + 2] = 8'h30 + nb;
            else if ($urandom_range(0, 1) == 1)
                seq[k + 2] = 8'h61 + nb - 8'd10;
            else
                seq[k + 2] = 8'h41 + nb - 8'd10;
            if (noisy && $urandom_range(0, 3) == 0)
                seq[k + 2] = 8'($urandom_range(0, 255));
        end
        for (int k = 0; k < keep; k++)
            push_char(seq[k]);
        if (keep == 6)
            n_escapes++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            char_in <= 8'h00;
            last_char <= 1'b0;
            wait_cnt <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_utf8(char_in, last_char);
                n_sent++;
            end
            if (!(in_valid && in_stall))
            begin
                if (text_q.size() == 0)
                    in_valid <= 1'b0;
                else if (text_q[0].drain && utf8_expected.size() != 0)
                    in_valid <= 1'b0;
                else if (wait_cnt < text_q[0].gap)
                begin
                    in_valid <= 1'b0;
                    wait_cnt <= wait_cnt + 1;
                end
                else
                begin
                    in_valid <= 1'b1;
                    char_in <= text_q[0].ch;
                    last_char <= text_q[0].fin;
                    wait_cnt <= 0;
                    void'(text_q.pop_front());
                end
            end
        end
    end

    // output monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (utf8_expected.size() == 0)
            begin
                $display("%0t: unexpected output, expected nothing, got %02h %0b %0b",
                         $time, out_byte, run_last, text_end);
                mismatches++;
            end
            else
            begin
                if (utf8_expected[0].b !== out_byte)
                begin
                    $display("%0t: out_byte mismatch, expected %02h, got %02h",
                             $time, utf8_expected[0].b, out_byte);
                    mismatches++;
                end
                if (utf8_expected[0].run_end !== run_last)
                begin
                    $display("%0t: run_last mismatch, expected %0b, got %0b",
                             $time, utf8_expected[0].run_end, run_last);
                    mismatches++;
                end
                if (utf8_expected[0].txt_end !== text_end)
                begin
                    $display("%0t: text_end mismatch, expected %0b, got %0b",
                             $time, utf8_expected[0].txt_end, text_end);
                    mismatches++;
                end
                void'(utf8_expected.pop_front());
            end
            n_checked++;
            if (n_checked % 24 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            stall_draw = rx_calm ? 0 : int'($urandom_range(0, 6));
            stall_left <= stall_draw;
            out_stall <= (stall_draw != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
        else
            out_stall <= 1'b0;
    end

    // stimulus and end of run
    initial
    begin
        int first_idx;
        int n_tok;
        int keep;
        bit forced_drain;
        logic [15:0] cp;
        logic [15:0] edge_cps [6];
        edge_cps = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
        forced_drain = 1'b0;

        // byte extremes, backslash then escape, three-byte and non-hex two-byte on final
        push_char(8'h00);
        push_char(8'hFF);
        push_char(uesc_pkg::CHAR_BSLASH);
        push_char(uesc_pkg::CHAR_BSLASH);
        push_char(uesc_pkg::CHAR_U);
        push_char("F");
        push_char("f");
        push_char("F");
        push_char("f");
        push_char(uesc_pkg::CHAR_BSLASH);
        push_char(uesc_pkg::CHAR_U);
        push_char("0");
        push_char("7");
        push_char("z");
        push_char("F");
        text_q[text_q.size() - 1].fin = 1'b1;
        // longest flush of a partial escape at the final byte
        push_char(uesc_pkg::CHAR_BSLASH);
        push_char(uesc_pkg::CHAR_U);
        push_char("1");
        push_char("2");
        push_char("Z");
        text_q[text_q.size() - 1].fin = 1'b1;
        // lone backslash as the final byte
        push_char(uesc_pkg::CHAR_BSLASH);
        text_q[text_q.size() - 1].fin = 1'b1;
        // backslash not followed by u, then text ending on the u
        push_char(uesc_pkg::CHAR_BSLASH);
        push_char("x");
        push_char(uesc_pkg::CHAR_BSLASH);
        push_char(uesc_pkg::CHAR_U);
        text_q[text_q.size() - 1].fin = 1'b1;
        n_texts = 4;

        // random texts mixing full escapes, raw bytes and partial escapes
        while (text_q.size() < 300)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            first_idx = text_q.size();
            n_tok = int'($urandom_range(1, 8));
            for (int t = 0; t < n_tok; t++)
            begin
                case ($urandom_range(0, 3))
                    0: cp = 16'($urandom_range(0, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    default: cp = edge_cps[$urandom_range(0, 5)];
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                        add_escape(cp, 6, $urandom_range(0, 4) == 0);
                    5, 6:
                        push_char(8'($urandom_range(0, 255)));
                    7:
                        for (int k = 0; k < $urandom_range(1, 4); k++)
                            push_char(8'($urandom_range(8'h20, 8'h7E)));
                    8:
                    begin
                        push_char(uesc_pkg::CHAR_BSLASH);
                        push_char(8'($urandom_range(0, 255)));
                    end
                    default:
                        add_escape(cp, int'($urandom_range(1, 5)), 1'b1);
                endcase
            end
            // some texts end inside an escape
            if ($urandom_range(0, 2) == 0)
            begin
                keep = int'($urandom_range(1, 5));
                add_escape(16'($urandom_range(0, 16'hFFFF)), keep, 1'b0);
                if (keep == 5 && $urandom_range(0, 1) == 1)
                    text_q[text_q.size() - 1].ch = 8'($urandom_range(0, 255));
            end
            text_q[text_q.size() - 1].fin = 1'b1;
            if (!forced_drain || $urandom_range(0, 5) == 0)
                text_q[first_idx].drain = 1'b1;
            forced_drain = 1'b1;
            n_texts++;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (text_q.size() != 0 || in_valid || utf8_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d text bytes in %0d texts with %0d full escapes",
                 n_sent, n_texts, n_escapes);
        $display("%0d output bytes checked under random gaps and stalls", n_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #200us;
        $display("timeout with %0d requests unsent and %0d bytes outstanding",
                 text_q.size(), utf8_expected.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
